>>> sv/b64_pkg.sv
// Shared types, constants and character-mapping functions for the base64 stream codec.
// Depends on nothing; the front, job queue, back and top-level files import it.
package b64_pkg;

	// Direction register codes.
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// Sizes of the message state.
	localparam int BUF_W = 12;
	localparam int CNT_W = 4;
	localparam int GRP_W = 2;

	// Job queue between front and back.
	localparam int JOB_DEPTH = 2;
	localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
	localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

	// Most results one item can cause, and the width of a slot index.
	localparam int MAX_RES = 4;
	localparam int RES_IDX_W = $clog2(MAX_RES);
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [6:0] NO_SYMBOL = 7'd64;

	// One classified item: the results it causes and how they close the message.
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] vals;
		logic [RES_CNT_W-1:0]    cnt;
		logic                    last;
		logic                    empty;
		logic                    stopped;
	} b64_job_t;

	// Six-bit symbol to alphabet character.
	function automatic logic [7:0] b64_char(input logic [5:0] s);
		logic [7:0] w;
		begin
			w = {2'b00, s};
			if (s < 6'd26) b64_char = 8'(8'd65 + w);
			else if (s < 6'd52) b64_char = 8'(8'd97 + w - 8'd26);
			else if (s < 6'd62) b64_char = 8'(8'd48 + w - 8'd52);
			else if (s == 6'd62) b64_char = 8'h2B;
			else b64_char = 8'h2F;
		end
	endfunction

	// Character to six-bit symbol; NO_SYMBOL outside the alphabet.
	function automatic logic [6:0] b64_symbol(input logic [7:0] c);
		begin
			if (c inside {[8'h41:8'h5A]}) b64_symbol = 7'(c - 8'h41);
			else if (c inside {[8'h61:8'h7A]}) b64_symbol = 7'(c - 8'h61 + 8'd26);
			else if (c inside {[8'h30:8'h39]}) b64_symbol = 7'(c - 8'h30 + 8'd52);
			else if (c == 8'h2B) b64_symbol = 7'd62;
			else if (c == 8'h2F) b64_symbol = 7'd63;
			else b64_symbol = NO_SYMBOL;
		end
	endfunction

endpackage

>>> sv/b64_stream_if.sv
// Valid/ready channel interfaces for the codec's input and result items.
// Standalone; no package needed.
interface b64_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_value;
	logic       in_last;
	modport source(output valid, output in_value, output in_last, input ready);
	modport sink(input valid, input in_value, input in_last, output ready);
endinterface

interface b64_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_value;
	logic       out_last;
	logic       out_empty;
	logic       out_stopped;
	modport source(output valid, output out_value, output out_last, output out_empty,
		output out_stopped, input ready);
	modport sink(input valid, input out_value, input out_last, input out_empty,
		input out_stopped, output ready);
endinterface

>>> sv/b64_front.sv
// Front part: accepts input items, keeps the message state and turns each item into a job.
// Depends on b64_pkg and the b64_in_if channel.
module b64_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	b64_in_if.sink            in_ch,
	input  logic              q_full,
	output logic              push,
	output b64_pkg::b64_job_t push_job
);
	import b64_pkg::*;

	logic             dir_q;
	logic [BUF_W-1:0] bitbuf_q, bitbuf_n;
	logic [CNT_W-1:0] bitcnt_q, bitcnt_n;
	logic [GRP_W-1:0] grp_q, grp_n;
	logic             halted_q, halted_n;

	logic             accept;
	logic [BUF_W-1:0] enc_buf, dec_buf;
	logic [5:0]       c0, c1;
	logic [1:0]       nchar;
	logic [CNT_W-1:0] rem, dcnt;
	logic             leftover;
	logic [GRP_W-1:0] grp_end, pads;
	logic [6:0]       sym;
	logic             emit;
	logic [7:0]       dbyte;
	logic             dec_halt;
	b64_job_t         job;

	assign in_ch.ready = !q_full;
	assign accept = in_ch.valid && !q_full;

	// Split the item into results and work out the next message state.
	always_comb begin
		job = '0;
		push = 1'b0;
		bitbuf_n = bitbuf_q;
		bitcnt_n = bitcnt_q;
		grp_n = grp_q;
		halted_n = halted_q;
		enc_buf = {bitbuf_q[3:0], in_ch.in_value};
		c0 = '0;
		c1 = '0;
		nchar = 2'd1;
		rem = '0;
		case (bitcnt_q)
			4'd0: begin
				c0 = enc_buf[7:2];
				c1 = {enc_buf[1:0], 4'b0000};
				rem = 4'd2;
			end
			4'd2: begin
				c0 = enc_buf[9:4];
				c1 = {enc_buf[3:0], 2'b00};
				rem = 4'd4;
			end
			default: begin
				c0 = enc_buf[11:6];
				c1 = enc_buf[5:0];
				nchar = 2'd2;
				rem = 4'd0;
			end
		endcase
		leftover = in_ch.in_last && (rem != '0);
		grp_end = GRP_W'(grp_q + nchar + {1'b0, leftover});
		pads = in_ch.in_last ? GRP_W'(-grp_end) : '0;
		sym = b64_symbol(in_ch.in_value);
		dec_buf = {bitbuf_q[5:0], sym[5:0]};
		dcnt = CNT_W'(bitcnt_q + 4'd6);
		dec_halt = halted_q || (sym == NO_SYMBOL);
		emit = !halted_q && (sym != NO_SYMBOL) && (dcnt >= 4'd8);
		case (dcnt)
			4'd8:    dbyte = dec_buf[7:0];
			4'd10:   dbyte = dec_buf[9:2];
			default: dbyte = dec_buf[11:4];
		endcase

		if (dir_q == DIR_ENCODE) begin
			// Up to two characters, a leftover character and padding on the last byte.
			job.vals[0] = b64_char(c0);
			job.vals[1] = b64_char(c1);
			job.vals[2] = PAD_CHAR;
			job.vals[3] = PAD_CHAR;
			job.cnt = RES_CNT_W'({1'b0, nchar} + {2'b00, leftover} + {1'b0, pads});
			job.last = in_ch.in_last;
			push = accept;
			bitbuf_n = enc_buf;
			bitcnt_n = rem;
			grp_n = GRP_W'(grp_q + nchar);
		end else begin
			// At most one byte; the last item always closes the message.
			job.vals[0] = emit ? dbyte : 8'h00;
			job.cnt = RES_CNT_W'(1);
			job.last = in_ch.in_last;
			job.empty = !emit;
			job.stopped = in_ch.in_last && dec_halt;
			push = accept && (emit || in_ch.in_last);
			halted_n = dec_halt;
			if (!halted_q && (sym != NO_SYMBOL)) begin
				bitbuf_n = dec_buf;
				bitcnt_n = emit ? CNT_W'(dcnt - 4'd8) : dcnt;
			end
		end
		if (in_ch.in_last) begin
			bitbuf_n = '0;
			bitcnt_n = '0;
			grp_n = '0;
			halted_n = 1'b0;
		end
	end

	assign push_job = job;

	// Direction register and message state; a direction write clears the message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_ENCODE;
			bitbuf_q <= '0;
			bitcnt_q <= '0;
			grp_q <= '0;
			halted_q <= 1'b0;
		end else if (cfg_we) begin
			dir_q <= cfg_wdata;
			bitbuf_q <= '0;
			bitcnt_q <= '0;
			grp_q <= '0;
			halted_q <= 1'b0;
		end else if (accept) begin
			bitbuf_q <= bitbuf_n;
			bitcnt_q <= bitcnt_n;
			grp_q <= grp_n;
			halted_q <= halted_n;
		end
	end
endmodule

>>> sv/b64_job_fifo.sv
// Short job queue between the front and back parts of the codec.
// Depends on b64_pkg for the job type and depth.
module b64_job_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64_pkg::b64_job_t push_job,
	output logic              full,
	input  logic              pop,
	output logic              nonempty,
	output b64_pkg::b64_job_t head
);
	import b64_pkg::*;

	b64_job_t             mem_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0] wptr_q, rptr_q;
	logic [JOB_CNT_W-1:0] count_q;

	assign full = (count_q == JOB_CNT_W'(JOB_DEPTH));
	assign nonempty = (count_q != '0);
	assign head = mem_q[rptr_q];

	// Storage for queued jobs.
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_job;
	end

	// Pointers wrap at the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : JOB_PTR_W'(wptr_q + 1'b1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : JOB_PTR_W'(rptr_q + 1'b1);
			end
			if (push && !pop) count_q <= JOB_CNT_W'(count_q + 1'b1);
			else if (pop && !push) count_q <= JOB_CNT_W'(count_q - 1'b1);
		end
	end
endmodule

>>> sv/b64_back.sv
// Back part: holds one job and hands out its results one item per cycle while the output is ready.
// Depends on b64_pkg and the b64_out_if channel.
module b64_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_nonempty,
	input  b64_pkg::b64_job_t q_head,
	output logic              pop,
	b64_out_if.source         out_ch
);
	import b64_pkg::*;

	b64_job_t             job_q;
	logic [RES_IDX_W-1:0] idx_q;
	logic                 busy_q;
	logic                 fin, taken;

	assign fin = (idx_q == RES_IDX_W'(job_q.cnt - 1'b1));
	assign taken = busy_q && out_ch.ready;
	assign pop = q_nonempty && (!busy_q || (taken && fin));

	// Current result; the message marks only ride on the job's final result.
	assign out_ch.valid = busy_q;
	assign out_ch.out_value = job_q.vals[idx_q];
	assign out_ch.out_last = job_q.last && fin;
	assign out_ch.out_empty = job_q.empty && fin;
	assign out_ch.out_stopped = job_q.stopped && fin;

	// Job payload.
	always_ff @(posedge clk) begin
		if (pop) job_q <= q_head;
	end

	// Slot index and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			busy_q <= 1'b0;
		end else if (pop) begin
			idx_q <= '0;
			busy_q <= 1'b1;
		end else if (taken) begin
			if (fin) busy_q <= 1'b0;
			else idx_q <= RES_IDX_W'(idx_q + 1'b1);
		end
	end
endmodule

>>> sv/base64_stream_codec_unit.sv
// Base64 stream codec top level: front, job queue and back.
// An accepted item's job passes through the queue into the back's job register, which
// offers its first result. Reset clears the direction to encode, the message state and the queue.
// Throughput: one item per cycle into the queue while it is not full; results leave one per
// cycle while the output is ready. An encoded byte yields up to four characters; decoding
// sustains one character per cycle.
module base64_stream_codec_unit (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	b64_in_if.sink    in_ch,
	b64_out_if.source out_ch
);
	import b64_pkg::*;

	logic     q_full, q_nonempty, push, pop;
	b64_job_t push_job, q_head;

	// Classify items into jobs.
	b64_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// Decouple the two sides.
	b64_job_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (pop),
		.nonempty(q_nonempty),
		.head    (q_head)
	);

	// Emit results.
	b64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_nonempty(q_nonempty),
		.q_head    (q_head),
		.pop       (pop),
		.out_ch    (out_ch)
	);
endmodule
